// ----- hdl/lkap_pkg.sv -----
// shared types and constants for the luma key alpha premultiply core
`timescale 1ns / 1ps
package lkap_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_GRAY_ENABLE = 2'd0;
	localparam logic [1:0] REG_KEY_ENABLE  = 2'd1;
	localparam logic [1:0] REG_THRESHOLD   = 2'd2;
	localparam logic [1:0] REG_EDGE        = 2'd3;

	localparam int CFG_W = 17;

	// q1.16 one
	localparam logic [16:0] Q_ONE = 17'd65536;

	// luma = floor((sum * 8192 + 15937) / 31875) via reciprocal and one correction
	localparam logic [30:0] LUMA_ROUND = 31'd15937;
	localparam logic [31:0] LUMA_DIV   = 32'd31875;
	localparam logic [62:0] LUMA_RECIP = 63'd2207646877;

	// quotient steps of the fade band divider
	localparam int DIV_STEPS = 17;

	// estimate of floor(y / 255) for y below 2^17: (y * 32897) >> 23, at most one too high
	localparam logic [32:0] DIV255_RECIP = 33'd32897;

	// how the fade of a pixel is decided
	typedef enum logic [1:0] {
		FADE_NONE,
		FADE_FULL,
		FADE_BAND
	} fade_mode_t;

	// pixel data that travels along the pipeline
	typedef struct packed {
		logic [2:0][7:0] c;
		logic [7:0]      a;
		logic [16:0]     luma;
		logic            fe;
		fade_mode_t      mode;
	} pix_t;

endpackage

// ----- hdl/luma_key_alpha_premultiply_core.sv -----
// top level of the luma key alpha premultiply core
`timescale 1ns / 1ps
// One BGRA pixel per item on the input channel (in_valid / in_ready), one
// processed pixel per item on the output channel (out_valid / out_ready).
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it
// only while no item is in flight. Threshold and edge saturate to 1.0.
// Throughput is one item per cycle while the output is not stalled. There are
// 27 register stages: four of luma and fade classification, seventeen of the
// bit-per-stage band divider, two of the smoothstep multiplies and four of the
// alpha and premultiply arithmetic including the output register.
// The whole pipeline moves on one enable: while the output item waits and
// out_ready is low, every stage holds and in_ready is low, so nothing is lost
// or repeated; in_ready follows out_ready in the same cycle.
// Reset clears all valid bits and sets grayscale and key off, threshold to
// 1.0 and edge to 0.
module luma_key_alpha_premultiply_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [lkap_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                blue_in,
	input  logic [7:0]                green_in,
	input  logic [7:0]                red_in,
	input  logic [7:0]                alpha_in,
	input  logic                      frame_end_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                blue_out,
	output logic [7:0]                green_out,
	output logic [7:0]                red_out,
	output logic [7:0]                alpha_out,
	output logic                      frame_end_out
);
	import lkap_pkg::*;

	// configuration registers
	logic        gray_q;
	logic        key_q;
	logic [16:0] thr_q;
	logic [16:0] edge_q;
	logic [16:0] cfg_sat;

	assign cfg_sat = (cfg_data > Q_ONE) ? Q_ONE : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_q <= 1'b0;
			key_q  <= 1'b0;
			thr_q  <= Q_ONE;
			edge_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAY_ENABLE: gray_q <= cfg_data[0];
				REG_KEY_ENABLE:  key_q  <= cfg_data[0];
				REG_THRESHOLD:   thr_q  <= cfg_sat;
				REG_EDGE:        edge_q <= cfg_sat;
				default:         ;
			endcase
		end
	end

	// global pipeline enable
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_d, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	// stage 1: input register and weighted channel sum
	pix_t        pix_s1;
	logic [17:0] sum_s1;

	// stage 2: luma estimate by reciprocal
	pix_t        pix_s2;
	logic [30:0] m_s2;
	logic [16:0] qe_s2;
	logic [30:0] m_c;
	logic [62:0] prod_c;

	assign m_c    = {sum_s1, 13'b0} + LUMA_ROUND;
	assign prod_c = 63'(m_c) * LUMA_RECIP;

	// stage 3: luma correction
	pix_t        pix_s3;
	logic [31:0] chk_c;
	logic [16:0] luma_c;

	assign chk_c  = 32'(qe_s2) * LUMA_DIV;
	assign luma_c = (chk_c > {1'b0, m_s2}) ? 17'(qe_s2 - 17'd1) : qe_s2;

	// stage 4: fade classification and divider operands
	pix_t        pix_s4;
	logic [31:0] num_s4;
	logic [16:0] den_s4;
	logic [17:0] lum_edge_c;
	logic [15:0] dist_c;
	fade_mode_t  mode_c;

	assign lum_edge_c = 18'(pix_s3.luma) + 18'(edge_q);
	assign dist_c     = 16'(lum_edge_c - 18'(thr_q));

	always_comb begin
		priority if (pix_s3.luma >= thr_q) begin
			mode_c = FADE_FULL;
		end else if (lum_edge_c <= 18'(thr_q) || edge_q == '0) begin
			mode_c = FADE_NONE;
		end else begin
			mode_c = FADE_BAND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1.c    <= {red_in, green_in, blue_in};
			pix_s1.a    <= alpha_in;
			pix_s1.luma <= '0;
			pix_s1.fe   <= frame_end_in;
			pix_s1.mode <= FADE_NONE;
			sum_s1      <= 18'(red_in) * 18'd299 + 18'(green_in) * 18'd587
				+ 18'(blue_in) * 18'd114;

			pix_s2 <= pix_s1;
			m_s2   <= m_c;
			qe_s2  <= prod_c[62:46];

			pix_s3 <= {pix_s2.c, pix_s2.a, luma_c, pix_s2.fe, pix_s2.mode};

			pix_s4 <= {pix_s3.c, pix_s3.a, pix_s3.luma, pix_s3.fe, mode_c};
			num_s4 <= {dist_c, 16'b0} + 32'(edge_q >> 1);
			den_s4 <= edge_q;
		end
	end

	// band position divider
	logic [16:0] quo_d;
	pix_t        pix_d;

	lkap_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s4),
		.num     (num_s4),
		.den     (den_s4),
		.in_pix  (pix_s4),
		.out_vld (vld_d),
		.quo     (quo_d),
		.out_pix (pix_d)
	);

	// stage 5: x squared and the smoothstep factor
	pix_t        pix_s5;
	logic [33:0] x2_s5;
	logic [17:0] t_s5;
	logic [16:0] x_c;

	assign x_c = (quo_d > Q_ONE) ? Q_ONE : quo_d;

	// stage 6: full smoothstep product
	pix_t        pix_s6;
	logic [51:0] s_s6;

	// stage 7: keep factor and alpha products
	pix_t            pix_s7;
	logic [16:0]     keep_s7;
	logic [2:0][15:0] ca_s7;
	logic [24:0]     la_s7;
	logic [16:0]     fade_c;
	logic [16:0]     keep_c;

	assign fade_c = 17'((s_s6 + 52'h80000000) >> 32);

	always_comb begin
		unique case (pix_s6.mode)
			FADE_FULL: keep_c = '0;
			FADE_BAND: keep_c = 17'(Q_ONE - fade_c);
			default:   keep_c = Q_ONE;
		endcase
	end

	// stage 8: products with keep
	pix_t             pix_s8;
	logic [2:0][32:0] p_s8;
	logic [41:0]      pg_s8;
	logic [24:0]      pa_s8;

	// stage 9: rounding of the premultiplied values
	pix_t             pix_s9;
	logic [2:0][16:0] y_s9;
	logic [7:0]       gk_s9;
	logic [7:0]       ak_s9;
	logic [7:0]       gn_s9;
	logic [9:0]       gk_c;
	logic [8:0]       ak_c;
	logic [8:0]       gn_c;
	logic [24:0]      lg_c;

	assign gk_c = 10'((pg_s8 + 42'h80000000) >> 32);
	assign ak_c = 9'((pa_s8 + 25'd32768) >> 16);
	assign lg_c = 25'(pix_s8.luma) * 25'd255;
	assign gn_c = 9'((lg_c + 25'd32768) >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_d;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s5 <= pix_d;
			x2_s5  <= 34'(x_c) * 34'(x_c);
			t_s5   <= 18'd196608 - {x_c, 1'b0};

			pix_s6 <= pix_s5;
			s_s6   <= 52'(x2_s5) * 52'(t_s5);

			pix_s7  <= pix_s6;
			keep_s7 <= keep_c;
			for (int i = 0; i < 3; i++) begin
				ca_s7[i] <= 16'(pix_s6.c[i]) * 16'(pix_s6.a);
			end
			la_s7 <= 25'(pix_s6.luma) * 25'(pix_s6.a);

			pix_s8 <= pix_s7;
			for (int i = 0; i < 3; i++) begin
				p_s8[i] <= 33'(ca_s7[i]) * 33'(keep_s7);
			end
			pg_s8 <= 42'(la_s7) * 42'(keep_s7);
			pa_s8 <= 25'(pix_s7.a) * 25'(keep_s7);

			pix_s9 <= pix_s8;
			for (int i = 0; i < 3; i++) begin
				y_s9[i] <= 17'((p_s8[i] + 33'd8355840) >> 16);
			end
			gk_s9 <= (gk_c > 10'd255) ? 8'd255 : gk_c[7:0];
			ak_s9 <= (ak_c > 9'd255) ? 8'd255 : ak_c[7:0];
			gn_s9 <= (gn_c > 9'd255) ? 8'd255 : gn_c[7:0];
		end
	end

	// output stage: divide by 255, select by mode
	logic [2:0][7:0]  col_c;
	logic [2:0][32:0] vp_c;
	logic [2:0][9:0]  ve_c;
	logic [2:0][9:0]  vc_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vp_c[i] = 33'(y_s9[i]) * DIV255_RECIP;
			ve_c[i] = vp_c[i][32:23];
			vc_c[i] = (18'(ve_c[i]) * 18'd255 > 18'(y_s9[i])) ? 10'(ve_c[i] - 10'd1) : ve_c[i];
			if (key_q) begin
				col_c[i] = gray_q ? gk_s9 : ((vc_c[i] > 10'd255) ? 8'd255 : vc_c[i][7:0]);
			end else begin
				col_c[i] = gray_q ? gn_s9 : pix_s9.c[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blue_out      <= col_c[0];
			green_out     <= col_c[1];
			red_out       <= col_c[2];
			alpha_out     <= key_q ? ak_s9 : 8'd255;
			frame_end_out <= pix_s9.fe;
		end
	end

endmodule

// ----- hdl/lkap_div.sv -----
// pipelined restoring divider for the fade band position, one quotient bit a stage
`timescale 1ns / 1ps
module lkap_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [31:0]       num,
	input  logic [16:0]       den,
	input  lkap_pkg::pix_t    in_pix,
	output logic              out_vld,
	output logic [16:0]       quo,
	output lkap_pkg::pix_t    out_pix
);
	import lkap_pkg::*;

	// stage registers, index k holds the item after k quotient bits
	logic              vld_s [1:DIV_STEPS];
	logic [16:0]       rem_s [1:DIV_STEPS];
	logic [16:0]       quo_s [1:DIV_STEPS];
	logic [31:0]       num_s [1:DIV_STEPS];
	logic [16:0]       den_s [1:DIV_STEPS];
	pix_t              pix_s [1:DIV_STEPS];

	genvar k;
	generate
		for (k = 0; k < DIV_STEPS; k++) begin : g_step
			logic        vld_src;
			logic [16:0] rem_src;
			logic [16:0] quo_src;
			logic [31:0] num_src;
			logic [16:0] den_src;
			pix_t        pix_src;
			logic [17:0] trial;
			logic        take;

			// stage source: ports for the first step, previous stage after
			if (k == 0) begin : g_first
				assign vld_src = in_vld;
				assign rem_src = {2'b00, num[31:17]};
				assign quo_src = '0;
				assign num_src = num;
				assign den_src = den;
				assign pix_src = in_pix;
			end else begin : g_next
				assign vld_src = vld_s[k];
				assign rem_src = rem_s[k];
				assign quo_src = quo_s[k];
				assign num_src = num_s[k];
				assign den_src = den_s[k];
				assign pix_src = pix_s[k];
			end

			// shift in the next numerator bit and try the subtraction
			assign trial = {rem_src, num_src[DIV_STEPS - 1 - k]};
			assign take  = trial >= {1'b0, den_src};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k + 1] <= 1'b0;
				end else if (en) begin
					vld_s[k + 1] <= vld_src;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k + 1] <= take ? 17'(trial - {1'b0, den_src}) : trial[16:0];
					quo_s[k + 1] <= {quo_src[15:0], take};
					num_s[k + 1] <= num_src;
					den_s[k + 1] <= den_src;
					pix_s[k + 1] <= pix_src;
				end
			end
		end
	endgenerate

	assign out_vld = vld_s[DIV_STEPS];
	assign quo     = quo_s[DIV_STEPS];
	assign out_pix = pix_s[DIV_STEPS];

endmodule

// ----- tb/sv/luma_key_alpha_premultiply_core_tb.sv -----
// testbench for the luma key alpha premultiply core
`timescale 1ns / 1ps
module luma_key_alpha_premultiply_core_tb;
	import lkap_pkg::*;

	localparam int LATENCY = 27;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] a;
		logic       fe;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_GRAY_ENABLE;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] blue_in = '0, green_in = '0, red_in = '0, alpha_in = '0;
	logic frame_end_in = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] blue_out, green_out, red_out, alpha_out;
	logic frame_end_out;

	// local copy of the settings
	bit gray_on, key_on;
	longint unsigned thr_q, edge_q;

	pixel_t expected_pixels[$];
	int mismatches = 0;
	longint cycles = 0;
	bit sink_busy = 1'b0;

	luma_key_alpha_premultiply_core i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	function automatic longint unsigned luma_q16(pixel_t p);
		longint unsigned s;
		s = (299 * p.r + 587 * p.g + 114 * p.b) * 64'd65536;
		return (s + 127500) / 255000;
	endfunction

	function automatic longint unsigned fade_q16(longint unsigned y);
		longint unsigned x, s;
		if (y >= thr_q) return 65536;
		if (y + edge_q <= thr_q || edge_q == 0) return 0;
		x = ((y + edge_q - thr_q) * 65536 + edge_q / 2) / edge_q;
		if (x > 65536) x = 65536;
		s = x * x * (3 * 65536 - 2 * x);
		return (s + (64'd1 << 31)) >> 32;
	endfunction

	function automatic logic [7:0] sat8(longint unsigned v);
		return v > 255 ? 8'd255 : v[7:0];
	endfunction

	// expected processed pixel
	function automatic pixel_t keyed_pixel(pixel_t p);
		pixel_t q;
		longint unsigned y, keep, c[3];
		c[0] = p.b; c[1] = p.g; c[2] = p.r;
		y = luma_q16(p);
		if (key_on) begin
			keep = 65536 - fade_q16(y);
			for (int i = 0; i < 3; i++)
				c[i] = gray_on ? (y * p.a * keep + (64'd1 << 31)) >> 32
					: (c[i] * p.a * keep + 8355840) / 16711680;
			q.a = sat8((p.a * keep + 32768) >> 16);
		end else begin
			for (int i = 0; i < 3; i++)
				if (gray_on) c[i] = (y * 255 + 32768) >> 16;
			q.a = 8'd255;
		end
		q.b = sat8(c[0]); q.g = sat8(c[1]); q.r = sat8(c[2]);
		q.fe = p.fe;
		return q;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result checker with random output stalls
	initial begin
		int stall;
		pixel_t w;
		forever begin
			@(posedge clk);
			if (sink_busy) begin
				if (out_valid && out_ready) begin
					if (expected_pixels.size() == 0)
						report("unexpected item", 0, 0);
					else begin
						w = expected_pixels.pop_front();
						if (blue_out !== w.b) report("blue", blue_out, w.b);
						if (green_out !== w.g) report("green", green_out, w.g);
						if (red_out !== w.r) report("red", red_out, w.r);
						if (alpha_out !== w.a) report("alpha", alpha_out, w.a);
						if (frame_end_out !== w.fe)
							report("frame end", frame_end_out, w.fe);
					end
				end
				stall = gap_len();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_pixel(input pixel_t p, input bit idle);
		int g;
		g = idle ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		blue_in <= p.b; green_in <= p.g; red_in <= p.r;
		alpha_in <= p.a; frame_end_in <= p.fe;
		do @(posedge clk); while (!in_ready);
		expected_pixels.push_back(keyed_pixel(p));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// one register write, the enable stays high for the caller to drop
	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] v);
		longint unsigned s;
		s = v > 65536 ? 65536 : v;
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_GRAY_ENABLE: gray_on = v[0];
			REG_KEY_ENABLE:  key_on = v[0];
			REG_THRESHOLD:   thr_q = s;
			default:         edge_q = s;
		endcase
	endtask

	task automatic set_all(bit gr, bit ky, logic [CFG_W-1:0] th, logic [CFG_W-1:0] ed);
		write_reg(REG_GRAY_ENABLE, {{(CFG_W - 1){1'b0}}, gr});
		write_reg(REG_KEY_ENABLE, {{(CFG_W - 1){1'b0}}, ky});
		write_reg(REG_THRESHOLD, th);
		write_reg(REG_EDGE, ed);
		cfg_we <= 1'b0;
	endtask

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.b = 8'($urandom_range(0, 255));
		p.g = 8'($urandom_range(0, 255));
		p.r = 8'($urandom_range(0, 255));
		p.a = 8'($urandom_range(0, 255));
		p.fe = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	// extremes of the channels under reset settings first, then a hard key and a gray key
	task automatic test_directed();
		pixel_t list[8];
		list[0] = {8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
		list[1] = {8'd255, 8'd255, 8'd255, 8'd255, 1'b1};
		list[2] = {8'd255, 8'd0, 8'd0, 8'd128, 1'b0};
		list[3] = {8'd0, 8'd255, 8'd0, 8'd1, 1'b0};
		list[4] = {8'd0, 8'd0, 8'd255, 8'd200, 1'b1};
		list[5] = {8'd170, 8'd85, 8'd51, 8'd255, 1'b0};
		list[6] = {8'd128, 8'd128, 8'd128, 8'd255, 1'b0};
		list[7] = {8'd10, 8'd200, 8'd90, 8'd77, 1'b1};
		foreach (list[i]) send_pixel(list[i], 1'b0);
		drain();
		// edge zero: hard key at mid gray
		set_all(1'b0, 1'b1, 17'd32768, 17'd0);
		foreach (list[i]) send_pixel(list[i], 1'b0);
		drain();
		// out-of-range values saturate to 1.0, so edge equals threshold
		set_all(1'b1, 1'b1, 17'h1FFFF, 17'h1FFFF);
		foreach (list[i]) send_pixel(list[i], 1'b0);
		drain();
	endtask

	// random pixels over a sweep of settings
	task automatic test_random();
		logic [CFG_W-1:0] th, ed;
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: th = 17'd0;
				1: th = 17'd65536;
				default: th = 17'($urandom_range(0, 17'h1FFFF));
			endcase
			case (ph % 3)
				0: ed = 17'd0;
				1: ed = 17'($urandom_range(1, 20000));
				default: ed = 17'($urandom_range(0, 17'h1FFFF));
			endcase
			set_all(ph[0], ph[1] | ph[2], th, ed);
			for (int n = 0; n < 100; n++)
				send_pixel(rand_pixel(), ph != 5);
			drain();
		end
	endtask

	initial begin
		gray_on = 0; key_on = 0; thr_q = 65536; edge_q = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sink_busy = 1'b1;
		test_directed();
		test_random();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// leftover expectations are caught by drain stalling into the watchdog
endmodule
